// File: hw/rtl/prr_pkg.sv
// Shared types and constants for the prefix rectangle range block.
`timescale 1ns / 1ps

package prr_pkg;

   // Configuration port geometry
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int SIZE_W     = 6;

   // Register index, taken from paddr[2]
   typedef enum logic {
      REG_MATRIX_SIZE = 1'b0,
      REG_UNMAPPED    = 1'b1
   } reg_index_type;

   // Position flags of one request within the matrix
   typedef struct packed {
      logic has_left;
      logic has_above;
      logic done;
   } pos_flags_type;

endpackage

// File: hw/rtl/prefix_rectangle_range.sv
// Top level: streaming two-dimensional prefix maximum, minimum and range.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+--------------------------------------
// request   | in        | req_valid/req_ready | req_element_value
// response  | out       | rsp_valid/rsp_ready | rsp_range_value, rsp_prefix_max,
//           |           |                     | rsp_prefix_min, rsp_matrix_done
// config    | in        | APB psel/penable    | paddr, pwdata, prdata (matrix_size)
//
// One request per cycle sustained while responses are taken: the line store is read on
// acceptance into the combine stage, which loads the output register that offers each response.
// Reset is synchronous; it returns the indices to row 0, column 0 and size to one.
// The line store needs no clearing pass: an entry is only used after the row above
// has written it. A stalled response holds the combine stage, which then holds
// the request side through req_ready.

module prefix_rectangle_range #(
   parameter int MAX_DIM    = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [VALUE_BITS-1:0]          req_element_value,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic        [VALUE_BITS-1:0]          rsp_range_value,
   output logic signed [VALUE_BITS-1:0]          rsp_prefix_max,
   output logic signed [VALUE_BITS-1:0]          rsp_prefix_min,
   output logic                                  rsp_matrix_done,
   // configuration port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [prr_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [prr_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [prr_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);

   localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   // configuration
   logic             size_write;
   logic [IDX_W-1:0] size_last;

   // position of the request on the input side
   logic                   idx_advance;
   logic [IDX_W-1:0]       idx_col;
   prr_pkg::pos_flags_type idx_flags;

   // combine stage
   logic                          s1_valid_ff, s1_valid_in;
   logic signed [VALUE_BITS-1:0]  s1_value_ff;
   logic [IDX_W-1:0]              s1_col_ff;
   prr_pkg::pos_flags_type        s1_flags_ff;
   logic                          s1_adv;

   logic [2*VALUE_BITS-1:0]       above_word;
   logic signed [VALUE_BITS-1:0]  above_max, above_min;
   logic signed [VALUE_BITS-1:0]  left_max_ff, left_max_in;
   logic signed [VALUE_BITS-1:0]  left_min_ff, left_min_in;
   logic signed [VALUE_BITS-1:0]  cand_max, cand_min;
   logic signed [VALUE_BITS-1:0]  new_max, new_min;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic        [VALUE_BITS-1:0]  rsp_range_ff;
   logic signed [VALUE_BITS-1:0]  rsp_max_ff, rsp_min_ff;
   logic                          rsp_done_ff;

   prr_csr #(
      .MAX_DIM (MAX_DIM),
      .IDX_W   (IDX_W)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .size_write (size_write),
      .size_last  (size_last)
   );

   // Advance the combine stage whenever the output register is free or draining;
   // take a new request whenever the combine stage is empty or advancing.
   assign s1_adv      = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready   = ~s1_valid_ff | s1_adv;
   assign idx_advance = req_valid & req_ready;

   prr_index_ctrl #(
      .IDX_W (IDX_W)
   ) u_index (
      .clock     (clock),
      .reset     (reset),
      .restart   (size_write),
      .advance   (idx_advance),
      .size_last (size_last),
      .col       (idx_col),
      .flags     (idx_flags)
   );

   // Read the column above on acceptance; write back the combined extremes as the
   // request leaves the combine stage. The two columns differ whenever the row
   // above is in use, so no forwarding path is needed.
   prr_line_store #(
      .DEPTH  (MAX_DIM),
      .ADDR_W (IDX_W),
      .DATA_W (2 * VALUE_BITS)
   ) u_line (
      .clock   (clock),
      .rd_en   (idx_advance),
      .rd_addr (idx_col),
      .rd_data (above_word),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data ({new_max, new_min})
   );

   assign above_max = above_word[2*VALUE_BITS-1:VALUE_BITS];
   assign above_min = above_word[VALUE_BITS-1:0];

   // Combine: element against left neighbour, then against the row above.
   always_comb begin
      cand_max = s1_value_ff;
      cand_min = s1_value_ff;
      if (s1_flags_ff.has_left && (left_max_ff > s1_value_ff)) begin
         cand_max = left_max_ff;
      end
      if (s1_flags_ff.has_left && (left_min_ff < s1_value_ff)) begin
         cand_min = left_min_ff;
      end
      new_max = cand_max;
      new_min = cand_min;
      if (s1_flags_ff.has_above && (above_max > cand_max)) begin
         new_max = above_max;
      end
      if (s1_flags_ff.has_above && (above_min < cand_min)) begin
         new_min = above_min;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (idx_advance) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      left_max_in  = s1_adv ? new_max : left_max_ff;
      left_min_in  = s1_adv ? new_min : left_min_ff;
      rsp_valid_in = s1_adv | (rsp_valid_ff & ~rsp_ready);
   end

   // control and running-extreme registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_max_ff  <= '0;
         left_min_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         left_max_ff  <= left_max_in;
         left_min_ff  <= left_min_in;
      end
   end

   // capture the request payload and its position
   always_ff @(posedge clock) begin
      if (idx_advance) begin
         s1_value_ff <= req_element_value;
         s1_col_ff   <= idx_col;
         s1_flags_ff <= idx_flags;
      end
   end

   // load the response; the range is never negative so the plain difference holds
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_range_ff <= VALUE_BITS'(new_max - new_min);
         rsp_max_ff   <= new_max;
         rsp_min_ff   <= new_min;
         rsp_done_ff  <= s1_flags_ff.done;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_value = rsp_range_ff;
   assign rsp_prefix_max  = rsp_max_ff;
   assign rsp_prefix_min  = rsp_min_ff;
   assign rsp_matrix_done = rsp_done_ff;

   // Line store: a read that is used never collides with the write in flight.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (idx_advance && s1_adv && idx_flags.has_above) |-> (idx_col != s1_col_ff))
      else $error("line store read and write hit the same column");

   // A response never shows a maximum below its minimum.
   a_ordered_extremes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_max_ff < rsp_min_ff))
      else $error("prefix maximum below prefix minimum");

   // The last element of the matrix returns the column counter to zero.
   a_wrap_after_done: assert property (@(posedge clock) disable iff (reset)
      (idx_advance && idx_flags.done && !size_write) |=> (idx_col == '0))
      else $error("column counter did not wrap after the last element");

   // A stalled combine stage holds its request.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_value_ff)))
      else $error("combine stage lost a stalled request");

endmodule

// File: hw/rtl/prr_csr.sv
// Configuration register file: matrix size register and its clamped last index.
`timescale 1ns / 1ps

module prr_csr #(
   parameter int MAX_DIM = 32,
   parameter int IDX_W   = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [prr_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [prr_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [prr_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready,
   output logic                                size_write,
   output logic [IDX_W-1:0]                    size_last
);

   localparam int CMP_W = (IDX_W + 1 > prr_pkg::SIZE_W) ? IDX_W + 1 : prr_pkg::SIZE_W;

   logic [prr_pkg::SIZE_W-1:0] size_ff;
   logic [prr_pkg::SIZE_W-1:0] size_in;
   prr_pkg::reg_index_type     reg_index;
   logic                       wr_access;

   assign pready     = 1'b1;
   assign wr_access  = psel & penable & pwrite & pready;
   assign reg_index  = prr_pkg::reg_index_type'(paddr[2]);

   always_comb begin
      size_write = 1'b0;
      size_in    = size_ff;
      prdata     = '0;
      unique case (reg_index)
         prr_pkg::REG_MATRIX_SIZE: begin
            size_write = wr_access;
            if (wr_access) begin
               size_in = pwdata[prr_pkg::SIZE_W-1:0];
            end
            prdata = prr_pkg::CSR_DATA_W'(size_ff);
         end
         prr_pkg::REG_UNMAPPED: begin
            prdata = '0;
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= prr_pkg::SIZE_W'(1);
      end else begin
         size_ff <= size_in;
      end
   end

   // zero counts as one, oversize clamps to the line store depth
   always_comb begin
      if (size_ff == '0) begin
         size_last = '0;
      end else if (CMP_W'(size_ff) > CMP_W'(MAX_DIM)) begin
         size_last = IDX_W'(MAX_DIM - 1);
      end else begin
         size_last = IDX_W'(size_ff - prr_pkg::SIZE_W'(1));
      end
   end

endmodule

// File: hw/rtl/prr_index_ctrl.sv
// Row and column counters that place each request within the matrix.
`timescale 1ns / 1ps

module prr_index_ctrl #(
   parameter int IDX_W = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   restart,
   input  logic                   advance,
   input  logic [IDX_W-1:0]       size_last,
   output logic [IDX_W-1:0]       col,
   output prr_pkg::pos_flags_type flags
);

   logic [IDX_W-1:0] col_ff, col_in;
   logic [IDX_W-1:0] row_ff, row_in;
   logic             col_end, row_end;

   assign col_end = (col_ff == size_last);
   assign row_end = (row_ff == size_last);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (advance) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + IDX_W'(1);
         end else begin
            col_in = col_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col             = col_ff;
   assign flags.has_left  = (col_ff != '0);
   assign flags.has_above = (row_ff != '0);
   assign flags.done      = col_end & row_end;

endmodule

// File: hw/rtl/prr_line_store.sv
// Line store of the previous row's prefix extremes, one read and one write port.
`timescale 1ns / 1ps

module prr_line_store #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold the read word while the consuming stage stalls
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sim/testbench.sv
// Testbench for the prefix rectangle range block: streamed matrices checked against a predictor.
`timescale 1ns / 1ps

module testbench;

   localparam int DIM_LIMIT     = 32;
   localparam int VW            = 32;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [VW-1:0] MOST_POS = 32'h7FFF_FFFF;
   localparam logic [VW-1:0] MOST_NEG = 32'h8000_0000;
   localparam logic [prr_pkg::CSR_ADDR_W-1:0] SIZE_ADDR = {prr_pkg::REG_MATRIX_SIZE, 2'b00};

   // Shapes of element stream, chosen afresh for every matrix, or every 256 elements at the largest size
   typedef enum int {
      MIX_RANDOM,
      MIX_CLUSTER,
      MIX_RISING,
      MIX_FALLING,
      MIX_EXTREME
   } element_mix_type;

   typedef struct packed {
      logic [VW-1:0] range_value;
      logic [VW-1:0] prefix_max;
      logic [VW-1:0] prefix_min;
      logic          matrix_done;
   } prefix_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic signed [VW-1:0]           req_element_value = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [VW-1:0]                  rsp_range_value;
   logic signed [VW-1:0]           rsp_prefix_max;
   logic signed [VW-1:0]           rsp_prefix_min;
   logic                           rsp_matrix_done;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [prr_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [prr_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [prr_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   // Predictor state: line store of the row above, running values to the left
   logic signed [VW-1:0]       line_max [DIM_LIMIT];
   logic signed [VW-1:0]       line_min [DIM_LIMIT];
   logic signed [VW-1:0]       run_max = '0;
   logic signed [VW-1:0]       run_min = '0;
   int                         col_pos = 0;
   int                         row_pos = 0;
   logic [prr_pkg::SIZE_W-1:0] size_reg = 6'd1;

   prefix_result_type expected_prefix [$];
   int error_count   = 0;
   int cycle_count   = 0;
   int sent_count    = 0;
   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;

   prefix_rectangle_range #(
      .MAX_DIM    (DIM_LIMIT),
      .VALUE_BITS (VW)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_range_value   (rsp_range_value),
      .rsp_prefix_max    (rsp_prefix_max),
      .rsp_prefix_min    (rsp_prefix_min),
      .rsp_matrix_done   (rsp_matrix_done),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Abandon a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // Size in use: zero counts as one, anything above the line store depth as the depth
   function automatic int active_size(logic [prr_pkg::SIZE_W-1:0] code);
      if (code == 0) return 1;
      if (code > DIM_LIMIT) return DIM_LIMIT;
      return int'(code);
   endfunction

   // Advance the predictor by one element and return the prefix extremes it yields
   function automatic prefix_result_type predict_prefix(logic signed [VW-1:0] element);
      int                   n;
      int                   c;
      int                   r;
      logic signed [VW-1:0] hi;
      logic signed [VW-1:0] lo;
      prefix_result_type    res;
      n  = active_size(size_reg);
      c  = col_pos;
      r  = row_pos;
      hi = element;
      lo = element;
      // First column has nothing to the left, first row nothing above
      if (c > 0) begin
         if (run_max > hi) hi = run_max;
         if (run_min < lo) lo = run_min;
      end
      if (r > 0) begin
         if (line_max[c] > hi) hi = line_max[c];
         if (line_min[c] < lo) lo = line_min[c];
      end
      line_max[c] = hi;
      line_min[c] = lo;
      run_max     = hi;
      run_min     = lo;
      res.range_value = hi - lo;
      res.prefix_max  = hi;
      res.prefix_min  = lo;
      res.matrix_done = (r == n - 1) && (c == n - 1);
      // Step along the row, wrapping to a new row and then to a new matrix
      if (c + 1 < n) begin
         col_pos = c + 1;
      end else begin
         col_pos = 0;
         row_pos = (r + 1 < n) ? r + 1 : 0;
      end
      return res;
   endfunction

   function automatic logic [VW-1:0] next_element(element_mix_type mix, logic [VW-1:0] base,
                                                  logic [VW-1:0] stride, int idx);
      case (mix)
         MIX_RANDOM:  return $urandom();
         MIX_CLUSTER: return base + $urandom_range(0, 511) - 256;
         MIX_RISING:  return base + stride * idx;
         MIX_FALLING: return base - stride * idx;
         default: begin
            case ($urandom_range(0, 4))
               0:       return MOST_POS;
               1:       return MOST_NEG;
               2:       return '0;
               3:       return '1;
               default: return 32'h0000_0001;
            endcase
         end
      endcase
   endfunction

   task automatic report_field(input string field, input logic [VW-1:0] want,
                               input logic [VW-1:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= 10)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
      end
   endtask

   // Check every accepted response against the oldest prediction; drive ready at random
   always @(posedge clock) begin : check_responses
      prefix_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_prefix.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected response: max %h min %h", rsp_prefix_max, rsp_prefix_min);
         end else begin
            want = expected_prefix.pop_front();
            report_field("range_value", want.range_value, rsp_range_value);
            report_field("prefix_max", want.prefix_max, rsp_prefix_max);
            report_field("prefix_min", want.prefix_min, rsp_prefix_min);
            report_field("matrix_done", VW'(want.matrix_done), VW'(rsp_matrix_done));
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Offer one request, idling beforehand at random, and hold it until taken
   task automatic send_element(input logic [VW-1:0] element);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_element_value <= element;
      expected_prefix.push_back(predict_prefix(element));
      sent_count++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and wait for every predicted response, then let the pipeline settle
   task automatic drain_requests();
      req_valid <= 1'b0;
      while (expected_prefix.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write matrix_size once the block is idle; the write restarts the matrix
   task automatic write_matrix_size(input logic [prr_pkg::CSR_DATA_W-1:0] value);
      drain_requests();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= SIZE_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      size_reg = value[prr_pkg::SIZE_W-1:0];
      col_pos  = 0;
      row_pos  = 0;
   endtask

   // Extremes, odd sizes, end-of-matrix wrap and a restart mid-matrix
   task automatic test_directed();
      // Reset size of one: every request is a whole matrix
      send_element(MOST_POS);
      send_element(MOST_NEG);
      // Zero is taken as one
      write_matrix_size(32'd0);
      send_element(32'h0001_0000);
      // Full-scale range across a 2x2 matrix
      write_matrix_size(32'd2);
      send_element(MOST_NEG);
      send_element(MOST_POS);
      send_element(32'h0000_0000);
      send_element(32'hFFFF_FFFF);
      // 3x3 exercising first row, first column and the interior, then wrap into a new matrix
      write_matrix_size(32'd3);
      send_element(32'h0005_0000);
      send_element(32'hFFFD_0000);
      send_element(32'h0000_0007);
      send_element(32'h0000_8000);
      send_element(32'h7FFF_0000);
      send_element(32'h8000_0001);
      send_element(32'hFFFF_FFFF);
      send_element(32'h0000_0001);
      send_element(32'h1234_5678);
      send_element(32'hFFFF_0000);
      send_element(32'h0001_0000);
      // Oversized code is clamped to the line store depth
      write_matrix_size(32'd40);
      send_element(32'h0000_0100);
      send_element(MOST_NEG);
      send_element(MOST_POS);
      // Junk in the upper bits is ignored; this write lands mid-matrix and restarts it
      write_matrix_size(32'hFFFF_FFC2);
      send_element(32'h0000_0003);
      send_element(32'h0000_0002);
      send_element(32'h0000_0004);
      send_element(32'h0000_0001);
   endtask

   // Mostly whole small matrices with random content; some cut short, a few large ones
   task automatic test_random_matrices(input int item_goal);
      int              stop_at;
      int              pick;
      int              size_code;
      int              n;
      int              count;
      logic [VW-1:0]   word;
      element_mix_type mix;
      logic [VW-1:0]   base;
      logic [VW-1:0]   stride;
      stop_at = sent_count + item_goal;
      mix     = MIX_RANDOM;
      base    = '0;
      stride  = '0;
      while (sent_count < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) size_code = 0;
         else if (pick < 10) size_code = $urandom_range(DIM_LIMIT + 1, 63);
         else if (pick < 75) size_code = $urandom_range(1, 6);
         else if (pick < 95) size_code = $urandom_range(7, 16);
         else size_code = $urandom_range(17, DIM_LIMIT);
         word = size_code;
         if ($urandom_range(0, 3) == 0) word = ($urandom() & ~32'h3F) | size_code;
         write_matrix_size(word);
         n = active_size(word[prr_pkg::SIZE_W-1:0]);
         if (n > 16) begin
            // Just over one row up to three rows, so the second row reads the line store unless cut short
            count = $urandom_range(n + 1, 3 * n);
         end else begin
            count = $urandom_range(1, 3) * n * n;
            if ($urandom_range(0, 3) == 0) count -= $urandom_range(0, n * n - 1);
         end
         // Keep the phase close to its share of requests
         if (count > stop_at - sent_count) count = stop_at - sent_count;
         for (int i = 0; i < count; i++) begin
            if (i % (n * n) == 0) begin
               mix    = element_mix_type'($urandom_range(0, 4));
               base   = $urandom();
               stride = $urandom_range(1, 1 << 20);
            end
            send_element(next_element(mix, base, stride, i % (n * n)));
         end
      end
   endtask

   // One complete matrix at the largest size, then a few requests into the next
   task automatic test_largest_matrix();
      element_mix_type mix;
      logic [VW-1:0]   base;
      logic [VW-1:0]   stride;
      mix    = MIX_RANDOM;
      base   = '0;
      stride = '0;
      write_matrix_size(DIM_LIMIT);
      for (int i = 0; i < DIM_LIMIT * DIM_LIMIT + 3; i++) begin
         if (i % 256 == 0) begin
            mix    = element_mix_type'($urandom_range(0, 4));
            base   = $urandom();
            stride = $urandom_range(1, 1 << 16);
         end
         send_element(next_element(mix, base, stride, i % 256));
      end
   endtask

   initial begin
      send_gap_pct  = 16;
      rsp_stall_pct = 51;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_matrices(60);
      send_gap_pct  = 51;
      rsp_stall_pct = 16;
      test_random_matrices(60);
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      test_random_matrices(40);
      test_largest_matrix();
      drain_requests();
      if (error_count == 0 && expected_prefix.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
